// ===== sv/rbd_pkg.sv =====
package rbd_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	// popped_value and occupancy, padded to whole bytes
	localparam int OUT_W  = ((DATA_W + CNT_W + 7) / 8) * 8;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT_BACK   = 3'd0,
		KIND_PUSH_FRONT = 3'd1,
		KIND_TAKE_FRONT = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_SWAP       = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FEW   = 2'd3
	} status_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] popped;
		status_t                  status;
		logic [CNT_W-1:0]         occupancy;
	} result_t;

	function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
		return (p == '0) ? LAST_ADDR : p - 1'b1;
	endfunction

endpackage

// ===== sv/rbd_ram.sv =====
module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== sv/rbd_ctrl.sv =====
module rbd_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              out_free,
	input  rbd_pkg::kind_t                    kind,
	input  logic signed [rbd_pkg::DATA_W-1:0] value,
	input  logic [rbd_pkg::DATA_W-1:0]        rdata,
	output logic                              in_ready,
	output rbd_pkg::ram_req_t                 ram_req,
	output rbd_pkg::result_t                  res
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_POP_RD  = 5'b00010,
		ST_SWAP_RB = 5'b00100,
		ST_SWAP_WA = 5'b01000,
		ST_SWAP_WB = 5'b10000
	} state_t;

	state_t                         state_q, state_d;
	logic [rbd_pkg::ADDR_W-1:0]     front_q, front_d;
	logic [rbd_pkg::ADDR_W-1:0]     back_q, back_d;
	logic [rbd_pkg::CNT_W-1:0]      count_q, count_d;
	logic [rbd_pkg::DATA_W-1:0]     a_q;
	logic                           fire;
	logic                           full, empty, few;
	logic [rbd_pkg::ADDR_W-1:0]     front_next;

	assign in_ready   = (state_q == ST_IDLE) && out_free;
	assign fire       = in_valid && in_ready;
	assign full       = (count_q == rbd_pkg::FULL_CNT);
	assign empty      = (count_q == '0);
	assign few        = (count_q < rbd_pkg::CNT_W'(2));
	assign front_next = rbd_pkg::ptr_inc(front_q);

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		back_d  = back_q;
		count_d = count_q;
		ram_req = '0;
		res     = '0;
		res.status = rbd_pkg::STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					res.valid = 1'b1;
					case (kind)
						rbd_pkg::KIND_PUT_BACK: begin
							if (full) begin
								res.status = rbd_pkg::STAT_FULL;
							end else begin
								ram_req = '{en: 1'b1, we: 1'b1, addr: back_q, wdata: value};
								back_d  = rbd_pkg::ptr_inc(back_q);
								count_d = count_q + 1'b1;
							end
						end
						rbd_pkg::KIND_PUSH_FRONT: begin
							if (full) begin
								res.status = rbd_pkg::STAT_FULL;
							end else begin
								front_d = rbd_pkg::ptr_dec(front_q);
								ram_req = '{en: 1'b1, we: 1'b1, addr: front_d, wdata: value};
								count_d = count_q + 1'b1;
							end
						end
						rbd_pkg::KIND_TAKE_FRONT: begin
							if (empty) begin
								res.status = rbd_pkg::STAT_EMPTY;
							end else begin
								ram_req.en   = 1'b1;
								ram_req.addr = front_q;
								front_d      = front_next;
								count_d      = count_q - 1'b1;
								res.valid    = 1'b0;
								state_d      = ST_POP_RD;
							end
						end
						rbd_pkg::KIND_POP_BACK: begin
							if (empty) begin
								res.status = rbd_pkg::STAT_EMPTY;
							end else begin
								back_d       = rbd_pkg::ptr_dec(back_q);
								ram_req.en   = 1'b1;
								ram_req.addr = back_d;
								count_d      = count_q - 1'b1;
								res.valid    = 1'b0;
								state_d      = ST_POP_RD;
							end
						end
						rbd_pkg::KIND_SWAP: begin
							if (few) begin
								res.status = rbd_pkg::STAT_FEW;
							end else begin
								ram_req.en   = 1'b1;
								ram_req.addr = front_q;
								res.valid    = 1'b0;
								state_d      = ST_SWAP_RB;
							end
						end
						default: begin
						end
					endcase
					res.occupancy = count_d;
				end
			end
			ST_POP_RD: begin
				// pointers and count already moved at accept
				res.valid     = 1'b1;
				res.popped    = rdata;
				res.occupancy = count_q;
				state_d       = ST_IDLE;
			end
			ST_SWAP_RB: begin
				ram_req.en   = 1'b1;
				ram_req.addr = front_next;
				state_d      = ST_SWAP_WA;
			end
			ST_SWAP_WA: begin
				// second entry arrives now, goes straight to the front slot
				ram_req = '{en: 1'b1, we: 1'b1, addr: front_q, wdata: rdata};
				state_d = ST_SWAP_WB;
			end
			ST_SWAP_WB: begin
				ram_req       = '{en: 1'b1, we: 1'b1, addr: front_next, wdata: a_q};
				res.valid     = 1'b1;
				res.occupancy = count_q;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	// hold the front word while the second one is read
	always_ff @(posedge clk) begin
		if (state_q == ST_SWAP_RB) begin
			a_q <= rdata;
		end
	end

endmodule

// ===== sv/ring_buffer_deque.sv =====
// channel   direction  tdata                          tuser
// s_*       in         value[31:0]                    kind[2:0]
// m_*       out        popped_value[31:0],            status[1:0]
//                      occupancy[42:32], zeros above
//
// push and failed operations: word ready the cycle after accept
// pop: registered memory read, then the word; swap: two reads and two writes
// through the single memory port
// reset clears pointers, count and the output valid flag; store contents are
// undefined until pushed
// s_tready is low while a pop or swap is in progress or a word waits unread
module ring_buffer_deque (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic signed [rbd_pkg::DATA_W-1:0] s_tdata,  // value
	input  logic [rbd_pkg::KIND_W-1:0]        s_tuser,  // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbd_pkg::OUT_W-1:0]         m_tdata,  // popped_value, occupancy, zero pad
	output logic [rbd_pkg::STAT_W-1:0]        m_tuser   // status
);

	rbd_pkg::ram_req_t                 ram_req;
	rbd_pkg::result_t                  res;
	logic [rbd_pkg::DATA_W-1:0]        rdata;
	logic                              out_free;
	logic                              m_tvalid_q;
	logic signed [rbd_pkg::DATA_W-1:0] popped_q;
	logic [rbd_pkg::STAT_W-1:0]        status_q;
	logic [rbd_pkg::CNT_W-1:0]         occ_q;

	assign out_free = !m_tvalid_q || m_tready;

	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.kind     (rbd_pkg::kind_t'(s_tuser)),
		.value    (s_tdata),
		.rdata    (rdata),
		.in_ready (s_tready),
		.ram_req  (ram_req),
		.res      (res)
	);

	rbd_ram #(
		.WIDTH (rbd_pkg::DATA_W),
		.DEPTH (rbd_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_req.en),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (rdata)
	);

	// the slot is empty or draining whenever a new word can be produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			popped_q <= res.popped;
			status_q <= res.status;
			occ_q    <= res.occupancy;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(rbd_pkg::OUT_W - rbd_pkg::DATA_W - rbd_pkg::CNT_W){1'b0}},
		occ_q, popped_q};

`ifndef NO_ASSERTIONS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[rbd_pkg::DATA_W +: rbd_pkg::CNT_W] <= rbd_pkg::FULL_CNT))
		else $error("occupancy above capacity");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == rbd_pkg::STAT_FULL)
		|-> (m_tdata[rbd_pkg::DATA_W +: rbd_pkg::CNT_W] == rbd_pkg::FULL_CNT))
		else $error("full status with room left");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == rbd_pkg::STAT_EMPTY)
		|-> (m_tdata[rbd_pkg::DATA_W +: rbd_pkg::CNT_W] == '0
			&& m_tdata[rbd_pkg::DATA_W-1:0] == '0))
		else $error("empty status with entries or data");

	a_few_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == rbd_pkg::STAT_FEW)
		|-> (m_tdata[rbd_pkg::DATA_W +: rbd_pkg::CNT_W] < rbd_pkg::CNT_W'(2)))
		else $error("swap refused with two or more entries");
`endif

endmodule

// ===== tb/deque_checker.sv =====
module deque_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [rbd_pkg::DATA_W-1:0] s_tdata,   // value
	input  logic [rbd_pkg::KIND_W-1:0] s_tuser,   // kind
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [rbd_pkg::OUT_W-1:0]  m_tdata,   // popped_value, occupancy, zero pad
	input  logic [rbd_pkg::STAT_W-1:0] m_tuser,   // status
	output int                         mismatches,
	output int                         outstanding,
	output int                         words_checked,
	output int                         full_rejects,
	output int                         empty_rejects,
	output int                         short_swaps,
	output int                         peak_fill
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [rbd_pkg::DATA_W-1:0] popped;
		rbd_pkg::status_t           status;
		logic [rbd_pkg::CNT_W-1:0]  occupancy;
	} deque_word_t;

	// shadow copy of the deque
	logic [rbd_pkg::DATA_W-1:0] shadow [rbd_pkg::DEPTH];
	logic [rbd_pkg::ADDR_W-1:0] head;
	logic [rbd_pkg::ADDR_W-1:0] tail;
	logic [rbd_pkg::CNT_W-1:0]  fill;
	deque_word_t                expected_words [$];

	function automatic logic [rbd_pkg::ADDR_W-1:0] ring_next(
		input logic [rbd_pkg::ADDR_W-1:0] p);
		return (p == rbd_pkg::ADDR_W'(rbd_pkg::DEPTH - 1)) ? '0 : rbd_pkg::ADDR_W'(p + 1);
	endfunction

	function automatic logic [rbd_pkg::ADDR_W-1:0] ring_prev(
		input logic [rbd_pkg::ADDR_W-1:0] p);
		return (p == '0) ? rbd_pkg::ADDR_W'(rbd_pkg::DEPTH - 1) : rbd_pkg::ADDR_W'(p - 1);
	endfunction

	function automatic deque_word_t deque_apply(input logic [rbd_pkg::KIND_W-1:0] op,
	                                            input logic [rbd_pkg::DATA_W-1:0] word);
		deque_word_t                r;
		logic [rbd_pkg::DATA_W-1:0] held;
		r.popped = '0;
		r.status = rbd_pkg::STAT_OK;
		case (op)
			rbd_pkg::KIND_PUT_BACK, rbd_pkg::KIND_PUSH_FRONT: begin
				if (fill == rbd_pkg::CNT_W'(rbd_pkg::DEPTH)) begin
					r.status = rbd_pkg::STAT_FULL;
					full_rejects++;
				end else if (op == rbd_pkg::KIND_PUT_BACK) begin
					shadow[tail] = word;
					tail = ring_next(tail);
					fill = fill + 1'b1;
				end else begin
					head = ring_prev(head);
					shadow[head] = word;
					fill = fill + 1'b1;
				end
			end
			rbd_pkg::KIND_TAKE_FRONT, rbd_pkg::KIND_POP_BACK: begin
				if (fill == '0) begin
					r.status = rbd_pkg::STAT_EMPTY;
					empty_rejects++;
				end else if (op == rbd_pkg::KIND_TAKE_FRONT) begin
					r.popped = shadow[head];
					head = ring_next(head);
					fill = fill - 1'b1;
				end else begin
					tail = ring_prev(tail);
					r.popped = shadow[tail];
					fill = fill - 1'b1;
				end
			end
			rbd_pkg::KIND_SWAP: begin
				if (fill < rbd_pkg::CNT_W'(2)) begin
					r.status = rbd_pkg::STAT_FEW;
					short_swaps++;
				end else begin
					held = shadow[head];
					shadow[head] = shadow[ring_next(head)];
					shadow[ring_next(head)] = held;
				end
			end
			default: ;
		endcase
		if (int'(fill) > peak_fill)
			peak_fill = int'(fill);
		r.occupancy = fill;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
	                               input logic [63:0] want);
		$display("chk: result %0d %s: got 0x%0h, expected 0x%0h",
		         words_checked, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		deque_word_t want;
		if (!arst_n) begin
			head = '0;
			tail = '0;
			fill = '0;
			expected_words.delete();
			outstanding = 0;
		end else begin
			// results leave before the word accepted on this same edge can produce one
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected", 64'(m_tdata), '0);
				end else begin
					want = expected_words[0];
					expected_words.delete(0);
					if (m_tdata[rbd_pkg::DATA_W-1:0] !== want.popped)
						report_mismatch("popped_value", 64'(m_tdata[rbd_pkg::DATA_W-1:0]),
						                64'(want.popped));
					if (m_tuser !== want.status)
						report_mismatch("status", 64'(m_tuser), 64'(want.status));
					if (m_tdata[rbd_pkg::DATA_W +: rbd_pkg::CNT_W] !== want.occupancy)
						report_mismatch("occupancy",
						                64'(m_tdata[rbd_pkg::DATA_W +: rbd_pkg::CNT_W]),
						                64'(want.occupancy));
					if (m_tdata[rbd_pkg::OUT_W-1:rbd_pkg::DATA_W+rbd_pkg::CNT_W] !== '0)
						report_mismatch("tdata pad",
						                64'(m_tdata[rbd_pkg::OUT_W-1:rbd_pkg::DATA_W+rbd_pkg::CNT_W]),
						                '0);
				end
			end
			if (s_tvalid && s_tready)
				expected_words.insert(expected_words.size(), deque_apply(s_tuser, s_tdata));
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE      = 10;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [rbd_pkg::DATA_W-1:0] s_tdata  = '0;   // value
	logic [rbd_pkg::KIND_W-1:0] s_tuser  = '0;   // kind
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [rbd_pkg::OUT_W-1:0]  m_tdata;         // popped_value, occupancy, zero pad
	logic [rbd_pkg::STAT_W-1:0] m_tuser;         // status

	bit idle_enable = 1'b0;
	int level       = 0;
	int sent        = 0;
	int stalled     = 0;

	int mismatches;
	int outstanding;
	int words_checked;
	int full_rejects;
	int empty_rejects;
	int short_swaps;
	int peak_fill;

	ring_buffer_deque dut (.*);

	deque_checker watch (.*);

	always #4 clk = ~clk;

	// sink side: random stall bursts
	initial begin
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stalled <= 0;
		end else if (stalled >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("tb: failure");
			$finish;
		end else begin
			stalled <= stalled + 1;
		end
	end

	function automatic logic [rbd_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [rbd_pkg::KIND_W-1:0] pick_kind(input int push_pct,
	                                                        input int pop_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return $urandom_range(0, 1) ? rbd_pkg::KIND_PUSH_FRONT : rbd_pkg::KIND_PUT_BACK;
		if (roll < push_pct + pop_pct)
			return $urandom_range(0, 1) ? rbd_pkg::KIND_TAKE_FRONT : rbd_pkg::KIND_POP_BACK;
		if (roll < 97)
			return rbd_pkg::KIND_SWAP;
		// undefined kinds above swap
		return rbd_pkg::KIND_W'($urandom_range(int'(rbd_pkg::KIND_SWAP) + 1,
		                                       (1 << rbd_pkg::KIND_W) - 1));
	endfunction

	task automatic send_word(input logic [rbd_pkg::KIND_W-1:0] op,
	                         input logic [rbd_pkg::DATA_W-1:0] word);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
		// rough fill level, only used to steer the traffic
		case (op)
			rbd_pkg::KIND_PUT_BACK, rbd_pkg::KIND_PUSH_FRONT:
				if (level < rbd_pkg::DEPTH) level++;
			rbd_pkg::KIND_TAKE_FRONT, rbd_pkg::KIND_POP_BACK:
				if (level > 0) level--;
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int n;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		idle_enable <= 1'b1;

		// empty store, single entry, front pointer wrapping below zero
		send_word(rbd_pkg::KIND_TAKE_FRONT, 32'h1234_5678);
		send_word(rbd_pkg::KIND_POP_BACK, 32'hffff_ffff);
		send_word(rbd_pkg::KIND_SWAP, 32'h0000_0001);
		send_word(rbd_pkg::KIND_PUT_BACK, 32'h7fff_ffff);
		send_word(rbd_pkg::KIND_SWAP, 32'h8000_0000);
		send_word(rbd_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
		send_word(rbd_pkg::KIND_SWAP, 32'h5555_5555);
		send_word(rbd_pkg::KIND_POP_BACK, 32'haaaa_aaaa);
		send_word(rbd_pkg::KIND_W'(int'(rbd_pkg::KIND_SWAP) + 1), 32'hffff_ffff);
		send_word(rbd_pkg::KIND_W'(int'(rbd_pkg::KIND_SWAP) + 2), 32'h0000_0000);
		send_word(rbd_pkg::KIND_W'((1 << rbd_pkg::KIND_W) - 1), 32'h8000_0000);
		send_word(rbd_pkg::KIND_PUT_BACK, 32'h0000_0000);
		send_word(rbd_pkg::KIND_PUT_BACK, 32'hffff_ffff);
		send_word(rbd_pkg::KIND_PUSH_FRONT, 32'h0000_0001);
		send_word(rbd_pkg::KIND_SWAP, 32'h0);
		send_word(rbd_pkg::KIND_TAKE_FRONT, 32'h0);
		send_word(rbd_pkg::KIND_TAKE_FRONT, 32'h0);
		send_word(rbd_pkg::KIND_POP_BACK, 32'h0);
		send_word(rbd_pkg::KIND_POP_BACK, 32'h0);
		send_word(rbd_pkg::KIND_TAKE_FRONT, 32'h0);

		// balanced traffic that keeps hitting the empty boundary
		for (n = 0; n < 250; n++) begin
			if (n % 50 == 0)
				idle_enable <= ($urandom_range(0, 3) != 0);
			send_word(pick_kind(42, 42), pick_value());
		end

		// fill to capacity, both pointers wrap on the way
		n = 0;
		while (level < rbd_pkg::DEPTH) begin
			if (n % 64 == 0)
				idle_enable <= ($urandom_range(0, 3) != 0);
			send_word(pick_kind(90, 5), pick_value());
			n++;
		end
		for (n = 0; n < 16; n++)
			send_word(pick_kind(70, 10), pick_value());

		// drain for a while with both sides streaming
		idle_enable <= 1'b0;
		for (n = 0; n < 180; n++)
			send_word(pick_kind(25, 65), pick_value());
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("summary: %0d words sent, %0d results checked, peak occupancy %0d of %0d",
		         sent, words_checked, peak_fill, rbd_pkg::DEPTH);
		$display("summary: rejected pushes on full %0d, pops on empty %0d, short swaps %0d",
		         full_rejects, empty_rejects, short_swaps);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
